// File: hdl/emgwfe_pkg.sv
// Shared types and fixed field widths for the EMG window feature extractor
`timescale 1ns / 1ps

package emgwfe_pkg;

  // fixed widths of the request and result fields
  localparam int SAMPLE_W   = 16;
  localparam int SMOOTHED_W = 19;
  localparam int IABS_W     = 25;
  localparam int MEAN_W     = 19;
  localparam int SSUM_W     = 43;
  localparam int VAR_W      = 37;
  localparam int RMS_W      = 19;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_MAG,
    ST_MUL,
    ST_SQSUM,
    ST_DIV,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

// File: hdl/emg_window_feature_extractor_unit.sv
// EMG window feature extractor: smoothing, window sums, serial divide and root
// Usage:
//   One signed sample request enters on in_valid/in_stall; one result request
//   with six fields leaves on out_valid/out_stall for every sample taken.
//   The block works on one sample at a time; in_stall is high from the cycle
//   after a request is taken until the sequencer returns to idle.
//   SMW is the smoothed width (SAMPLE_BITS + clog2(AVERAGE_TAPS)) and SQW the
//   square-sum width (2*SMW - 1 + clog2(WINDOW_LENGTH), at most 64).
//   Each sample passes through the bit-serial squaring (SMW steps), the
//   restoring constant dividers (one quotient bit per cycle, SQW steps) and
//   the restoring square root (one root bit per cycle).
//   Both histories sit in RAMs; a wrap flag per ring makes never-written
//   entries read as zero, so no clearing pass is needed after reset.
//   Reset (rst_n low, synchronous) empties the rings and zeroes all sums.
//   The result sits in an output register; while out_stall holds it, a new
//   sample is still accepted and computed, and only the final load waits.
`timescale 1ns / 1ps

module emg_window_feature_extractor_unit #(
  parameter int AVERAGE_TAPS  = 8,
  parameter int WINDOW_LENGTH = 64,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [emgwfe_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [emgwfe_pkg::SMOOTHED_W-1:0]  out_smoothed,
  output logic [emgwfe_pkg::IABS_W-1:0]             out_integrated_abs,
  output logic [emgwfe_pkg::MEAN_W-1:0]             out_mean_abs,
  output logic [emgwfe_pkg::SSUM_W-1:0]             out_square_sum,
  output logic [emgwfe_pkg::VAR_W-1:0]              out_variance,
  output logic [emgwfe_pkg::RMS_W-1:0]              out_rms
);

  // derived widths
  localparam int SMW      = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
  localparam int ABW      = SMW + $clog2(WINDOW_LENGTH);
  localparam int SQW_FULL = 2 * SMW - 1 + $clog2(WINDOW_LENGTH);
  localparam int SQW      = (SQW_FULL > 64) ? 64 : SQW_FULL;
  localparam int PW       = 2 * SMW;
  localparam int RPW      = $clog2(AVERAGE_TAPS);
  localparam int SPW      = $clog2(WINDOW_LENGTH);
  localparam int DVW      = $clog2(WINDOW_LENGTH) + 1;
  localparam int NR       = (SQW + 1) / 2;
  localparam int RADW     = 2 * NR;
  localparam int CW       = $clog2(SQW + 1);

  localparam logic [DVW-1:0] DIV_W   = DVW'(WINDOW_LENGTH);
  localparam logic [DVW-1:0] DIV_WM1 = DVW'(WINDOW_LENGTH - 1);
  localparam logic [RPW-1:0] RAW_LAST = RPW'(AVERAGE_TAPS - 1);
  localparam logic [SPW-1:0] SMO_LAST = SPW'(WINDOW_LENGTH - 1);

  // one restoring divide step: quotient bit on top, new remainder below
  function automatic logic [DVW-1:0] div_step(input logic [DVW-2:0] rem,
                                              input logic           din,
                                              input logic [DVW-1:0] dsr);
    logic [DVW-1:0] r2;
    logic           q;
    r2 = {rem, din};
    q  = 1'b0;
    if (r2 >= dsr) begin
      r2 = r2 - dsr;
      q  = 1'b1;
    end
    return {q, r2[DVW-2:0]};
  endfunction

  emgwfe_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [RPW-1:0]     raw_pos_r, raw_pos_nxt;
  logic               raw_full_r, raw_full_nxt;
  logic [SPW-1:0]     smo_pos_r, smo_pos_nxt;
  logic               smo_full_r, smo_full_nxt;
  logic [SMW-1:0]     raw_sum_r, raw_sum_nxt;
  logic [ABW-1:0]     abs_sum_r, abs_sum_nxt;
  logic [SQW-1:0]     sq_sum_r, sq_sum_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [SMW-1:0]     x_r, x_nxt;
  logic signed [SMW-1:0] s_r, s_nxt;
  logic [SMW-1:0]     old_s_r, old_s_nxt;
  logic [SMW-1:0]     ma_r, ma_nxt, mo_r, mo_nxt;
  logic [PW-1:0]      mcn_r, mcn_nxt, mco_r, mco_nxt;
  logic [SMW-1:0]     mpn_r, mpn_nxt, mpo_r, mpo_nxt;
  logic [PW-1:0]      prn_r, prn_nxt, pro_r, pro_nxt;
  logic [SQW-1:0]     dva_r, dva_nxt, dvw_r, dvw_nxt, dvv_r, dvv_nxt;
  logic [DVW-2:0]     rma_r, rma_nxt, rmw_r, rmw_nxt, rmv_r, rmv_nxt;
  logic [RADW-1:0]    rad_r, rad_nxt;
  logic [NR-1:0]      root_r, root_nxt;
  logic [NR+1:0]      root_rem_r, root_rem_nxt;

  logic signed [emgwfe_pkg::SMOOTHED_W-1:0] o_smo_r, o_smo_nxt;
  logic [emgwfe_pkg::IABS_W-1:0]            o_iabs_r, o_iabs_nxt;
  logic [emgwfe_pkg::MEAN_W-1:0]            o_mean_r, o_mean_nxt;
  logic [emgwfe_pkg::SSUM_W-1:0]            o_ssum_r, o_ssum_nxt;
  logic [emgwfe_pkg::VAR_W-1:0]             o_var_r, o_var_nxt;
  logic [emgwfe_pkg::RMS_W-1:0]             o_rms_r, o_rms_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   raw_we, smo_we;
  logic [SMW-1:0]         raw_rdata, smo_rdata;
  logic [SAMPLE_BITS-1:0] samp_bits;
  logic [SMW-1:0]         x_ext;
  logic [DVW-1:0]         stp_a, stp_w, stp_v;
  logic [SQW-1:0]         dvw_step;
  logic [NR+3:0]          rt_r2, rt_trial;
  logic [63:0]            s_wide, abs_wide, mean_wide, sq_wide, var_wide, rms_wide;

  // handshake
  assign in_stall  = (state_r != emgwfe_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // sample bits above SAMPLE_BITS are dropped (zero-padded when SAMPLE_BITS is wider), then sign extended
  generate
    if (SAMPLE_BITS <= emgwfe_pkg::SAMPLE_W) begin : g_narrow
      assign samp_bits = in_sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign samp_bits = {{(SAMPLE_BITS - emgwfe_pkg::SAMPLE_W){1'b0}}, in_sample};
    end
  endgenerate
  assign x_ext = {{(SMW - SAMPLE_BITS){samp_bits[SAMPLE_BITS-1]}}, samp_bits};

  // raw sample ring
  emgwfe_ram #(.WIDTH(SMW), .DEPTH(AVERAGE_TAPS)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_pos_r),
    .wdata (x_r),
    .raddr (raw_pos_r),
    .rdata (raw_rdata)
  );

  // smoothed value ring
  emgwfe_ram #(.WIDTH(SMW), .DEPTH(WINDOW_LENGTH)) u_smo_ram (
    .clk   (clk),
    .we    (smo_we),
    .waddr (smo_pos_r),
    .wdata (s_r),
    .raddr (smo_pos_r),
    .rdata (smo_rdata)
  );

  // divider and root step logic
  assign stp_a    = div_step(rma_r, dva_r[SQW-1], DIV_W);
  assign stp_w    = div_step(rmw_r, dvw_r[SQW-1], DIV_W);
  assign stp_v    = div_step(rmv_r, dvv_r[SQW-1], DIV_WM1);
  assign dvw_step = {dvw_r[SQW-2:0], stp_w[DVW-1]};
  assign rt_r2    = {root_rem_r, rad_r[RADW-1:RADW-2]};
  assign rt_trial = (NR + 4)'({root_r, 2'b01});

  // result fields widened before masking to their widths
  assign s_wide    = {{(64 - SMW){s_r[SMW-1]}}, s_r};
  assign abs_wide  = 64'(abs_sum_r);
  assign mean_wide = 64'(dva_r);
  assign sq_wide   = 64'(sq_sum_r);
  assign var_wide  = 64'(dvv_r);
  assign rms_wide  = 64'(root_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emgwfe_pkg::ST_IDLE:   if (in_acc) state_nxt = emgwfe_pkg::ST_SMOOTH;
      emgwfe_pkg::ST_SMOOTH: state_nxt = emgwfe_pkg::ST_MAG;
      emgwfe_pkg::ST_MAG:    state_nxt = emgwfe_pkg::ST_MUL;
      emgwfe_pkg::ST_MUL:    if (cnt_r == CW'(1)) state_nxt = emgwfe_pkg::ST_SQSUM;
      emgwfe_pkg::ST_SQSUM:  state_nxt = emgwfe_pkg::ST_DIV;
      emgwfe_pkg::ST_DIV:    if (cnt_r == CW'(1)) state_nxt = emgwfe_pkg::ST_ROOT;
      emgwfe_pkg::ST_ROOT:   if (cnt_r == CW'(1)) state_nxt = emgwfe_pkg::ST_DONE;
      emgwfe_pkg::ST_DONE:   if (out_free) state_nxt = emgwfe_pkg::ST_IDLE;
      default:               state_nxt = emgwfe_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    cnt_nxt      = cnt_r;
    raw_pos_nxt  = raw_pos_r;
    raw_full_nxt = raw_full_r;
    smo_pos_nxt  = smo_pos_r;
    smo_full_nxt = smo_full_r;
    raw_sum_nxt  = raw_sum_r;
    abs_sum_nxt  = abs_sum_r;
    sq_sum_nxt   = sq_sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    x_nxt        = x_r;
    s_nxt        = s_r;
    old_s_nxt    = old_s_r;
    ma_nxt       = ma_r;
    mo_nxt       = mo_r;
    mcn_nxt      = mcn_r;
    mco_nxt      = mco_r;
    mpn_nxt      = mpn_r;
    mpo_nxt      = mpo_r;
    prn_nxt      = prn_r;
    pro_nxt      = pro_r;
    dva_nxt      = dva_r;
    dvw_nxt      = dvw_r;
    dvv_nxt      = dvv_r;
    rma_nxt      = rma_r;
    rmw_nxt      = rmw_r;
    rmv_nxt      = rmv_r;
    rad_nxt      = rad_r;
    root_nxt     = root_r;
    root_rem_nxt = root_rem_r;
    o_smo_nxt    = o_smo_r;
    o_iabs_nxt   = o_iabs_r;
    o_mean_nxt   = o_mean_r;
    o_ssum_nxt   = o_ssum_r;
    o_var_nxt    = o_var_r;
    o_rms_nxt    = o_rms_r;
    raw_we       = 1'b0;
    smo_we       = 1'b0;
    case (state_r)
      // latch the sample; both rings are read at their current slots
      emgwfe_pkg::ST_IDLE: begin
        if (in_acc) begin
          x_nxt = x_ext;
        end
      end
      // moving sum update, store raw sample, pick up the leaving smoothed value
      emgwfe_pkg::ST_SMOOTH: begin
        raw_sum_nxt = raw_sum_r + x_r - (raw_full_r ? raw_rdata : '0);
        s_nxt       = raw_sum_nxt;
        old_s_nxt   = smo_full_r ? smo_rdata : '0;
        raw_we      = 1'b1;
        if (raw_pos_r == RAW_LAST) begin
          raw_pos_nxt  = '0;
          raw_full_nxt = 1'b1;
        end else begin
          raw_pos_nxt = raw_pos_r + RPW'(1);
        end
      end
      // magnitudes, start both serial squarings, store smoothed value
      emgwfe_pkg::ST_MAG: begin
        ma_nxt  = s_r[SMW-1] ? (SMW'(0) - SMW'(s_r)) : SMW'(s_r);
        mo_nxt  = old_s_r[SMW-1] ? (SMW'(0) - old_s_r) : old_s_r;
        mcn_nxt = PW'(ma_nxt);
        mco_nxt = PW'(mo_nxt);
        mpn_nxt = ma_nxt;
        mpo_nxt = mo_nxt;
        prn_nxt = '0;
        pro_nxt = '0;
        cnt_nxt = CW'(SMW);
        smo_we  = 1'b1;
        if (smo_pos_r == SMO_LAST) begin
          smo_pos_nxt  = '0;
          smo_full_nxt = 1'b1;
        end else begin
          smo_pos_nxt = smo_pos_r + SPW'(1);
        end
      end
      // shift-add squaring, one multiplier bit per cycle
      emgwfe_pkg::ST_MUL: begin
        if (mpn_r[0]) prn_nxt = prn_r + mcn_r;
        if (mpo_r[0]) pro_nxt = pro_r + mco_r;
        mcn_nxt = {mcn_r[PW-2:0], 1'b0};
        mco_nxt = {mco_r[PW-2:0], 1'b0};
        mpn_nxt = {1'b0, mpn_r[SMW-1:1]};
        mpo_nxt = {1'b0, mpo_r[SMW-1:1]};
        cnt_nxt = cnt_r - CW'(1);
      end
      // window sums, then load the dividers
      emgwfe_pkg::ST_SQSUM: begin
        abs_sum_nxt = abs_sum_r - ABW'(mo_r) + ABW'(ma_r);
        sq_sum_nxt  = sq_sum_r - SQW'(pro_r) + SQW'(prn_r);
        dva_nxt     = SQW'(abs_sum_nxt);
        dvw_nxt     = sq_sum_nxt;
        dvv_nxt     = sq_sum_nxt;
        rma_nxt     = '0;
        rmw_nxt     = '0;
        rmv_nxt     = '0;
        cnt_nxt     = CW'(SQW);
      end
      // restoring division by the window length and by one less
      emgwfe_pkg::ST_DIV: begin
        dva_nxt = {dva_r[SQW-2:0], stp_a[DVW-1]};
        dvw_nxt = dvw_step;
        dvv_nxt = {dvv_r[SQW-2:0], stp_v[DVW-1]};
        rma_nxt = stp_a[DVW-2:0];
        rmw_nxt = stp_w[DVW-2:0];
        rmv_nxt = stp_v[DVW-2:0];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          rad_nxt      = RADW'(dvw_step);
          root_nxt     = '0;
          root_rem_nxt = '0;
          cnt_nxt      = CW'(NR);
        end
      end
      // restoring square root, two radicand bits per cycle
      emgwfe_pkg::ST_ROOT: begin
        rad_nxt = {rad_r[RADW-3:0], 2'b00};
        if (rt_r2 >= rt_trial) begin
          root_rem_nxt = (NR + 2)'(rt_r2 - rt_trial);
          root_nxt     = {root_r[NR-2:0], 1'b1};
        end else begin
          root_rem_nxt = (NR + 2)'(rt_r2);
          root_nxt     = {root_r[NR-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      // hand the result to the output register once it is free
      emgwfe_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_smo_nxt     = s_wide[emgwfe_pkg::SMOOTHED_W-1:0];
          o_iabs_nxt    = abs_wide[emgwfe_pkg::IABS_W-1:0];
          o_mean_nxt    = mean_wide[emgwfe_pkg::MEAN_W-1:0];
          o_ssum_nxt    = sq_wide[emgwfe_pkg::SSUM_W-1:0];
          o_var_nxt     = var_wide[emgwfe_pkg::VAR_W-1:0];
          o_rms_nxt     = rms_wide[emgwfe_pkg::RMS_W-1:0];
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emgwfe_pkg::ST_IDLE;
      cnt_r       <= '0;
      raw_pos_r   <= '0;
      raw_full_r  <= 1'b0;
      smo_pos_r   <= '0;
      smo_full_r  <= 1'b0;
      raw_sum_r   <= '0;
      abs_sum_r   <= '0;
      sq_sum_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      raw_pos_r   <= raw_pos_nxt;
      raw_full_r  <= raw_full_nxt;
      smo_pos_r   <= smo_pos_nxt;
      smo_full_r  <= smo_full_nxt;
      raw_sum_r   <= raw_sum_nxt;
      abs_sum_r   <= abs_sum_nxt;
      sq_sum_r    <= sq_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    s_r        <= s_nxt;
    old_s_r    <= old_s_nxt;
    ma_r       <= ma_nxt;
    mo_r       <= mo_nxt;
    mcn_r      <= mcn_nxt;
    mco_r      <= mco_nxt;
    mpn_r      <= mpn_nxt;
    mpo_r      <= mpo_nxt;
    prn_r      <= prn_nxt;
    pro_r      <= pro_nxt;
    dva_r      <= dva_nxt;
    dvw_r      <= dvw_nxt;
    dvv_r      <= dvv_nxt;
    rma_r      <= rma_nxt;
    rmw_r      <= rmw_nxt;
    rmv_r      <= rmv_nxt;
    rad_r      <= rad_nxt;
    root_r     <= root_nxt;
    root_rem_r <= root_rem_nxt;
    o_smo_r    <= o_smo_nxt;
    o_iabs_r   <= o_iabs_nxt;
    o_mean_r   <= o_mean_nxt;
    o_ssum_r   <= o_ssum_nxt;
    o_var_r    <= o_var_nxt;
    o_rms_r    <= o_rms_nxt;
  end

  assign out_smoothed       = o_smo_r;
  assign out_integrated_abs = o_iabs_r;
  assign out_mean_abs       = o_mean_r;
  assign out_square_sum     = o_ssum_r;
  assign out_variance       = o_var_r;
  assign out_rms            = o_rms_r;

  // a taken request always starts the smoothing step
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == emgwfe_pkg::ST_SMOOTH)
    else $error("accepted request did not start smoothing");

  // a new result only comes from the final state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == emgwfe_pkg::ST_DONE)
    else $error("result raised outside the final state");

  // serial squaring has finished with exact products
  a_square_exact: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == emgwfe_pkg::ST_SQSUM |-> prn_r == ma_r * ma_r && pro_r == mo_r * mo_r)
    else $error("serial square mismatch");

  // division remainders end below their divisors
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == emgwfe_pkg::ST_ROOT |->
      DVW'(rma_r) < DIV_W && DVW'(rmw_r) < DIV_W && DVW'(rmv_r) < DIV_WM1)
    else $error("divider remainder out of range");

  // the finished root leaves a remainder no larger than twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == emgwfe_pkg::ST_DONE |-> root_rem_r <= (NR + 2)'({root_r, 1'b0}))
    else $error("square root remainder too large");

endmodule

// File: hdl/emgwfe_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module emgwfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the EMG window feature extractor
`timescale 1ns / 1ps

module tb_top;
  import emgwfe_pkg::*;

  localparam int TAPS   = 8;
  localparam int WINDOW = 64;

  // one result request of the block
  typedef struct packed {
    logic signed [SMOOTHED_W-1:0] smoothed;
    logic [IABS_W-1:0]            integrated_abs;
    logic [MEAN_W-1:0]            mean_abs;
    logic [SSUM_W-1:0]            square_sum;
    logic [VAR_W-1:0]             variance;
    logic [RMS_W-1:0]             rms;
  } feature_t;

  // directed row: sample plus an optional hand-computed result
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    feature_t            features;
  } stim_row_t;

  typedef enum int {
    BURST_HOLD_PEAK,
    BURST_FULL_RANGE,
    BURST_QUIET,
    BURST_FLIP,
    BURST_SILENCE
  } burst_kind_t;

  // first rows follow from a cleared window; the rest go through the predictor
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{16'h8000, 1'b1, '{-19'sd32768, 25'd32768, 19'd512, 43'd1073741824,
                       37'd17043521, 19'd4096}},
    '{16'h8000, 1'b1, '{-19'sd65536, 25'd98304, 19'd1536, 43'd5368709120,
                       37'd85217605, 19'd9158}},
    '{16'h7fff, 1'b0, '0},
    '{16'h7fff, 1'b0, '0},
    '{16'h7fff, 1'b0, '0},
    '{16'h7fff, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'hffff, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'haaaa, 1'b0, '0},
    '{16'h00ff, 1'b0, '0},
    '{16'hff00, 1'b0, '0},
    '{16'h7fff, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h1234, 1'b0, '0},
    '{16'hedcc, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMOOTHED_W-1:0] out_smoothed;
  logic [IABS_W-1:0] out_integrated_abs;
  logic [MEAN_W-1:0] out_mean_abs;
  logic [SSUM_W-1:0] out_square_sum;
  logic [VAR_W-1:0] out_variance;
  logic [RMS_W-1:0] out_rms;

  // predictor state
  logic signed [SAMPLE_W-1:0]   raw_ring [TAPS];
  logic [$clog2(TAPS)-1:0]      raw_idx;
  logic signed [SMOOTHED_W-1:0] raw_acc;
  logic signed [SMOOTHED_W-1:0] smooth_ring [WINDOW];
  logic [$clog2(WINDOW)-1:0]    smooth_idx;
  logic [63:0]                  abs_acc;
  logic [63:0]                  sq_acc;

  feature_t pending_features [$];
  int send_idle_pct;
  int recv_stall_pct;
  int samples_sent;
  int results_checked;
  int full_scale_results;
  int errors;

  emg_window_feature_extractor_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_smoothed       (out_smoothed),
    .out_integrated_abs (out_integrated_abs),
    .out_mean_abs       (out_mean_abs),
    .out_square_sum     (out_square_sum),
    .out_variance       (out_variance),
    .out_rms            (out_rms)
  );

  always #5 clk = ~clk;

  // floor square root, one root bit per pass
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // moving average, window sums and derived features for one sample
  task automatic advance_window(input logic signed [SAMPLE_W-1:0] x, output feature_t f);
    logic signed [63:0] s64;
    logic signed [63:0] o64;
    logic [63:0] ma;
    logic [63:0] mo;
    raw_acc = raw_acc + x - raw_ring[raw_idx];
    raw_ring[raw_idx] = x;
    raw_idx = raw_idx + 1'b1;
    s64 = 64'(raw_acc);
    o64 = 64'(smooth_ring[smooth_idx]);
    ma = s64[63] ? -s64 : s64;
    mo = o64[63] ? -o64 : o64;
    abs_acc = abs_acc - mo + ma;
    sq_acc = sq_acc - mo * mo + ma * ma;
    smooth_ring[smooth_idx] = raw_acc;
    smooth_idx = smooth_idx + 1'b1;
    f.smoothed       = raw_acc;
    f.integrated_abs = abs_acc[IABS_W-1:0];
    f.mean_abs       = MEAN_W'(abs_acc / WINDOW);
    f.square_sum     = sq_acc[SSUM_W-1:0];
    f.variance       = VAR_W'(sq_acc / (WINDOW - 1));
    f.rms            = RMS_W'(floor_root(sq_acc / WINDOW));
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // offer one sample request, wait for acceptance, record its expectation
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input feature_t typed_features);
    int gap;
    feature_t f;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 130) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_sample <= SAMPLE_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_window(s, f);
    pending_features.push_back(typed ? typed_features : f);
    samples_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_features.size() != 0);
  endtask

  // random bursts of signal shapes, until the phase has its sample count
  task automatic run_bursts(input int n_items);
    int count;
    int len;
    int pick;
    burst_kind_t kind;
    logic [SAMPLE_W-1:0] s;
    logic polarity;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) kind = BURST_HOLD_PEAK;
      else if (pick < 50) kind = BURST_FULL_RANGE;
      else if (pick < 75) kind = BURST_QUIET;
      else if (pick < 85) kind = BURST_FLIP;
      else kind = BURST_SILENCE;
      polarity = 1'($urandom_range(1));
      case (kind)
        BURST_HOLD_PEAK: len = $urandom_range(72, 90);
        BURST_SILENCE:   len = $urandom_range(64, 72);
        BURST_FLIP:      len = $urandom_range(8, 40);
        default:         len = $urandom_range(10, 60);
      endcase
      // last burst of the phase is cut to the remaining count
      if (len > n_items - count) len = n_items - count;
      for (int i = 0; i < len; i++) begin
        case (kind)
          BURST_HOLD_PEAK: s = polarity ? 16'h7fff : 16'h8000;
          BURST_FULL_RANGE: s = SAMPLE_W'($urandom());
          BURST_QUIET: s = SAMPLE_W'($signed($urandom_range(511)) - 256);
          BURST_FLIP: begin
            s = polarity ? 16'h7fff : 16'h8000;
            polarity = ~polarity;
          end
          default: s = '0;
        endcase
        send_sample(s, 1'b0, '0);
      end
      count += len;
    end
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin : result_check
    feature_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_features.size() == 0) begin
        $display("%0t: result with no expectation, expected none actual smoothed %0d",
                 $time, out_smoothed);
        errors++;
      end else begin
        want = pending_features.pop_front();
        check_field("smoothed", 64'(want.smoothed), 64'(out_smoothed));
        check_field("integrated_abs", 64'(want.integrated_abs), 64'(out_integrated_abs));
        check_field("mean_abs", 64'(want.mean_abs), 64'(out_mean_abs));
        check_field("square_sum", 64'(want.square_sum), 64'(out_square_sum));
        check_field("variance", 64'(want.variance), 64'(out_variance));
        check_field("rms", 64'(want.rms), 64'(out_rms));
        results_checked++;
        if (want.mean_abs == MEAN_W'(262144)) full_scale_results++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // stimulus
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    send_idle_pct = 8;
    recv_stall_pct = 53;
    samples_sent = 0;
    results_checked = 0;
    full_scale_results = 0;
    errors = 0;
    for (int i = 0; i < TAPS; i++) raw_ring[i] = '0;
    for (int i = 0; i < WINDOW; i++) smooth_ring[i] = '0;
    raw_idx = '0;
    raw_acc = '0;
    smooth_idx = '0;
    abs_acc = '0;
    sq_acc = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].features);

    // three pacing phases: slow receiver, slow sender, full speed
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 8;  recv_stall_pct = 53; end
        1: begin send_idle_pct = 53; recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      drain_results();
      run_bursts(384);
    end

    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d samples over three pacing phases, checked %0d results",
             samples_sent, results_checked);
    $display("%0d results came from a full-scale window", full_scale_results);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
hdl/emgwfe_pkg.sv
hdl/emgwfe_ram.sv
hdl/emg_window_feature_extractor_unit.sv
dv/tb_top.sv
